>>> src/skt_pkg.sv
// ============================================================================
// skt_pkg
// Shared types and constants of the sorted key table.
// ============================================================================
package skt_pkg;

  // Number of records the table can hold.
  localparam int unsigned TABLE_DEPTH = 128;

  // Index into the record memory, and a count that can also hold TABLE_DEPTH.
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths of the request and response beats.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PL_W     = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned USED_W   = 8;

  // One memory word holds a key above its payload.
  localparam int unsigned ENTRY_W = KEY_W + PL_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_UPDATE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_e;

endpackage

>>> src/skt_if.sv
// ============================================================================
// skt_req_if / skt_rsp_if
// Valid/ready channels carrying request and response beats of the table.
// ============================================================================
interface skt_req_if
  import skt_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [KEY_W-1:0] key;
  logic [PL_W-1:0]         payload;

  modport source (output valid, operation, key, payload, input ready);
  modport sink   (input valid, operation, key, payload, output ready);
endinterface

interface skt_rsp_if
  import skt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [PL_W-1:0]     found_payload;
  logic [USED_W-1:0]   entries_used;

  modport source (output valid, status, position, found_payload, entries_used, input ready);
  modport sink   (input valid, status, position, found_payload, entries_used, output ready);
endinterface

>>> src/skt_ram.sv
// ============================================================================
// skt_ram
// Generic memory with one write port and one registered read port.
// ============================================================================
module skt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sorted_key_table_top.sv
// ============================================================================
// sorted_key_table_top
// Table of records kept in ascending order of a signed key, with payloads.
// ============================================================================
// The block keeps up to TABLE_DEPTH records, each a signed 32-bit key and an
// 8-bit payload, in ascending key order in one memory with a write port and a
// registered read port. A request beat asks for an insert, a lookup or a
// payload update, and every request yields exactly one response beat. Lookup
// and update find the key by binary search; each probe reads the memory in
// S_PROBE, then compares the key in S_CMP. An insert searches the same way
// and, if it misses, moves every larger record up one place, one record per
// cycle through the read and write ports together, and writes the new record
// into the gap in S_PLACE. Each request ends in S_DONE, which hands its
// result to the output register. An insert into a full table or of a present
// key is refused with no change. The memory needs no clearing after reset:
// only entries below the record count are ever used. A new request is taken
// whenever the sequencer is idle, even while the previous response still
// waits in the output register.
// ============================================================================
module sorted_key_table_top
  import skt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  skt_req_if.sink    req,
  skt_rsp_if.source  rsp
);

  // Sequencer and work registers.
  state_e                  state_q, state_d;
  logic [OP_W-1:0]         op_q, op_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [PL_W-1:0]         pl_q, pl_d;
  logic [CNT_W-1:0]        count_q, count_d;

  // Search window [lo, hiex) and the probed index.
  logic [CNT_W-1:0]        lo_q, lo_d;
  logic [CNT_W-1:0]        hiex_q, hiex_d;
  logic [IDX_W-1:0]        mid_q, mid_d;

  // Shift pointer and the pending write that follows each shift read in the next cycle.
  logic [CNT_W-1:0]        p_q, p_d;
  logic                    pend_q, pend_d;
  logic [IDX_W-1:0]        pend_addr_q, pend_addr_d;

  // Result of the item being worked on.
  status_e                 res_status_q, res_status_d;
  logic [IDX_W-1:0]        res_pos_q, res_pos_d;
  logic [PL_W-1:0]         res_fp_q, res_fp_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q, out_status_d;
  logic [POS_W-1:0]        out_pos_q, out_pos_d;
  logic [PL_W-1:0]         out_fp_q, out_fp_d;
  logic [USED_W-1:0]       out_used_q, out_used_d;

  // Memory ports.
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;

  logic [CNT_W:0]          mid_sum;
  logic [IDX_W-1:0]        mid_w;
  logic signed [KEY_W-1:0] rd_key;
  logic [PL_W-1:0]         rd_pl;
  logic                    out_free;
  logic                    is_full;
  logic                    op_valid;
  logic                    window_open;

  skt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The midpoint always lies inside a non-empty window; with distinct keys any
  // index in the window finds the same record, so rounding does not matter.
  assign mid_sum     = {1'b0, lo_q} + {1'b0, hiex_q};
  assign mid_w       = mid_sum[IDX_W:1];
  assign rd_key      = signed'(ram_rdata[ENTRY_W-1:PL_W]);
  assign rd_pl       = ram_rdata[PL_W-1:0];
  assign out_free    = !out_valid_q || rsp.ready;
  assign is_full     = (count_q == CNT_W'(TABLE_DEPTH));
  assign window_open = (lo_q < hiex_q);
  assign op_valid    = (req.operation == OP_INSERT) || (req.operation == OP_LOOKUP) ||
                       (req.operation == OP_UPDATE);

  assign req.ready = (state_q == S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          if (!op_valid || ((req.operation == OP_INSERT) && is_full)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (window_open) begin
          state_d = S_CMP;
        end else if (op_q == OP_INSERT) begin
          state_d = S_SHIFT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CMP: begin
        state_d = (rd_key == key_q) ? S_DONE : S_PROBE;
      end
      S_SHIFT: begin
        if (p_q == lo_q) begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    op_d         = op_q;
    key_d        = key_q;
    pl_d         = pl_q;
    count_d      = count_q;
    lo_d         = lo_q;
    hiex_d       = hiex_q;
    mid_d        = mid_q;
    p_d          = p_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_fp_d     = res_fp_q;
    out_valid_d  = out_valid_q && !rsp.ready;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_fp_d     = out_fp_q;
    out_used_d   = out_used_q;
    ram_we       = 1'b0;
    ram_waddr    = pend_addr_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = mid_w;

    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          op_d         = req.operation;
          key_d        = req.key;
          pl_d         = req.payload;
          lo_d         = '0;
          hiex_d       = count_q;
          res_status_d = ST_NOT_FOUND;
          res_pos_d    = '0;
          res_fp_d     = '0;
          if ((req.operation == OP_INSERT) && is_full) begin
            res_status_d = ST_FULL;
          end
        end
      end
      S_PROBE: begin
        mid_d = mid_w;
        if (!window_open && (op_q == OP_INSERT)) begin
          p_d    = count_q;
          pend_d = 1'b0;
        end
      end
      S_CMP: begin
        if (rd_key == key_q) begin
          if (op_q == OP_INSERT) begin
            res_status_d = ST_DUPLICATE;
          end else if (op_q == OP_UPDATE) begin
            res_status_d = ST_OK;
            res_pos_d    = mid_q;
            res_fp_d     = pl_q;
            ram_we       = 1'b1;
            ram_waddr    = mid_q;
            ram_wdata    = {key_q, pl_q};
          end else begin
            res_status_d = ST_OK;
            res_pos_d    = mid_q;
            res_fp_d     = rd_pl;
          end
        end else if (rd_key < key_q) begin
          lo_d = CNT_W'(mid_q) + CNT_W'(1);
        end else begin
          hiex_d = CNT_W'(mid_q);
        end
      end
      S_SHIFT: begin
        // Write the record read last cycle one place up.
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q;
          ram_wdata = ram_rdata;
        end
        if (p_q != lo_q) begin
          ram_raddr   = IDX_W'(p_q - CNT_W'(1));
          pend_d      = 1'b1;
          pend_addr_d = IDX_W'(p_q);
          p_d         = p_q - CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
      end
      S_PLACE: begin
        ram_we       = 1'b1;
        ram_waddr    = IDX_W'(lo_q);
        ram_wdata    = {key_q, pl_q};
        count_d      = count_q + CNT_W'(1);
        res_status_d = ST_OK;
        res_pos_d    = IDX_W'(lo_q);
        res_fp_d     = pl_q;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_pos_d    = POS_W'(res_pos_q);
          out_fp_d     = res_fp_q;
          out_used_d   = USED_W'(count_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    pl_q         <= pl_d;
    lo_q         <= lo_d;
    hiex_q       <= hiex_d;
    mid_q        <= mid_d;
    p_q          <= p_d;
    pend_addr_q  <= pend_addr_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_fp_q     <= res_fp_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_fp_q     <= out_fp_d;
    out_used_q   <= out_used_d;
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.status        = out_status_q;
  assign rsp.position      = out_pos_q;
  assign rsp.found_payload = out_fp_q;
  assign rsp.entries_used  = out_used_q;

`ifndef SYNTHESIS
  // The record count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("record count exceeds table depth");

  // The memory is written only by an update hit, a shift or the final place.
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CMP || state_q == S_SHIFT || state_q == S_PLACE))
    else $error("memory written outside of update, shift or place");

  // The count moves only when a new record has just been placed.
  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == S_PLACE))
    else $error("record count changed without an insert");

  // A refused or missed request reports no position and no payload.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && (rsp.status != ST_OK)) |->
      (rsp.position == '0 && rsp.found_payload == '0))
    else $error("non-success response carries position or payload");
`endif

endmodule
